/* rtl/av_srg_pkg.sv */
package av_srg_pkg;

	localparam int TAG_W   = 8;
	localparam int FR_W    = 13;
	localparam int TS_W    = 63;
	localparam int PAD_W   = 16;
	localparam int STAMP_W = 64;
	localparam int RATE_W  = 18;
	localparam int OFF_W   = 40;
	localparam int ACT_W   = 2;
	localparam int NSC_W   = 30;
	localparam int NUM_W   = PAD_W + NSC_W;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 64;

	localparam logic [NSC_W-1:0]   NS_PER_S       = 30'd1000000000;
	localparam logic [STAMP_W-1:0] STALE_NS       = 64'd1000000000;
	localparam logic [STAMP_W-1:0] BAD_DIFF_NS    = 64'd5000000000;
	localparam logic [STAMP_W-1:0] STILL_LIMIT_NS = 64'd100000000;
	localparam logic [STAMP_W-1:0] WINDOW_NS      = 64'd75000000;

	localparam logic [ACT_W-1:0] ACT_PLAY   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DROP   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REJECT = 2'd2;

	localparam logic REG_RATE   = 1'b0;
	localparam logic REG_OFFSET = 1'b1;

	typedef struct packed {
		logic load;
		logic clear;
		logic prep;
		logic enq;
		logic div_start;
		logic still_upd;
		logic mul_pad;
		logic adj_ld;
		logic rd;
		logic diff;
		logic pop;
		logic push;
		logic push_last;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic div_done;
		logic count_zero;
		logic hold;
		logic pnd_vld;
		logic out_free;
		logic drop;
	} sts_t;

endpackage

/* rtl/av_srg_div.sv */
module av_srg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [av_srg_pkg::NUM_W-1:0]  dividend,
	input  logic [av_srg_pkg::RATE_W-1:0] divisor,
	output logic                          done,
	output logic [av_srg_pkg::NUM_W-1:0]  quotient
);
	import av_srg_pkg::*;

	localparam int STEPS = NUM_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [NUM_W-1:0]  quo_q;
	logic [RATE_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [NUM_W-1:0]  nq;
	logic [RATE_W-1:0] nr;

	always_comb begin
		logic [RATE_W:0] t;
		nq = quo_q;
		nr = rem_q;
		for (int i = 0; i < 2; i++) begin
			t  = {nr, nq[NUM_W-1]};
			nq = {nq[NUM_W-2:0], 1'b0};
			if (t >= {1'b0, divisor}) begin
				t     = t - {1'b0, divisor};
				nq[0] = 1'b1;
			end
			nr = t[RATE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= nq;
			rem_q <= nr;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/av_srg_dp.sv */
module av_srg_dp #(
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_FRAMES  = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           op,
	input  logic [av_srg_pkg::TAG_W-1:0]   block_tag,
	input  logic [av_srg_pkg::FR_W-1:0]    frame_count,
	input  logic [av_srg_pkg::TS_W-1:0]    audio_ts,
	input  logic [av_srg_pkg::TS_W-1:0]    video_ts,
	input  logic [av_srg_pkg::TS_W-1:0]    now_ns,
	input  logic [av_srg_pkg::PAD_W-1:0]   pad_frames,
	input  logic [av_srg_pkg::RATE_W-1:0]  rate,
	input  logic [av_srg_pkg::OFF_W-1:0]   offset,
	input  av_srg_pkg::cmd_t               cmd,
	output av_srg_pkg::sts_t               sts,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [av_srg_pkg::TAG_W-1:0]   out_tag,
	output logic [av_srg_pkg::ACT_W-1:0]   action,
	output logic [av_srg_pkg::FR_W-1:0]    out_frames,
	output logic                           last
);
	import av_srg_pkg::*;

	localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int E_W = STAMP_W + FR_W + TAG_W;
	localparam logic [CW:0] DEPTH_L = (CW+1)'(QUEUE_DEPTH);
	localparam logic [STAMP_W-1:0] NEG_BAD = ~BAD_DIFF_NS + 64'd1;
	localparam logic [STAMP_W-1:0] NEG_WIN = ~WINDOW_NS + 64'd1;

	logic [E_W-1:0]     mem [QUEUE_DEPTH];
	logic [E_W-1:0]     rd_q;
	logic [HW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic [TS_W-1:0]    last_q;
	logic [TS_W-1:0]    first_q;
	logic [STAMP_W-1:0] still_q;
	logic [TAG_W-1:0]   tag_q;
	logic [FR_W-1:0]    frames_q;
	logic [TS_W-1:0]    ats_q;
	logic [TS_W-1:0]    vts_q;
	logic [TS_W-1:0]    now_q;
	logic [PAD_W-1:0]   pad_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [NUM_W-1:0]   prod_q;
	logic [STAMP_W-1:0] adj_q;
	logic               bad_q;
	logic [STAMP_W-1:0] diff_q;
	logic               pnd_vld_q;
	logic [TAG_W-1:0]   pnd_tag_q;
	logic [ACT_W-1:0]   pnd_act_q;
	logic [FR_W-1:0]    pnd_fr_q;
	logic               out_valid_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic [ACT_W-1:0]   out_act_q;
	logic [FR_W-1:0]    out_fr_q;
	logic               out_last_q;

	logic [FR_W-1:0]    fr_sat;
	logic [HW-1:0]      tail;
	logic [CW:0]        tsum;
	logic [HW-1:0]      head_nx;
	logic               full;
	logic               stale;
	logic [PAD_W-1:0]   mul_in;
	logic [RATE_W-1:0]  divisor;
	logic               div_done;
	logic [NUM_W-1:0]   quo;
	logic [STAMP_W:0]   still_sum;
	logic               neg;
	logic               far;
	logic               win;
	logic               bad_all;
	logic               out_free;

	assign fr_sat = ({4'b0, frame_count} > 17'(MAX_FRAMES)) ? FR_W'(MAX_FRAMES) : frame_count;
	assign tsum   = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign tail   = (tsum >= DEPTH_L) ? HW'(tsum - DEPTH_L) : HW'(tsum);
	assign head_nx = ((CW+1)'(head_q) + 1'b1 >= DEPTH_L) ? '0 : head_q + 1'b1;
	assign full   = (count_q == CW'(QUEUE_DEPTH));
	assign stale  = (({1'b0, now_q} - {1'b0, last_q}) > STALE_NS);
	assign mul_in = cmd.mul_pad ? pad_q : PAD_W'(frames_q);
	assign divisor = (rate == '0) ? RATE_W'(1) : rate;
	assign still_sum = {1'b0, still_q} + (STAMP_W+1)'(quo);

	assign neg     = diff_q[STAMP_W-1];
	assign far     = neg ? (diff_q < NEG_BAD) : (diff_q > BAD_DIFF_NS);
	assign win     = neg ? (diff_q < NEG_WIN) : (diff_q > WINDOW_NS);
	assign bad_all = bad_q | far;
	assign out_free = !out_valid_q || out_ready;

	av_srg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.enq && !full)
			mem[tail] <= {stamp_q, frames_q, tag_q};
		if (cmd.rd)
			rd_q <= mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tag_q    <= block_tag;
			frames_q <= fr_sat;
			ats_q    <= audio_ts;
			vts_q    <= video_ts;
			now_q    <= now_ns;
			pad_q    <= pad_frames;
		end
		if (cmd.prep)
			stamp_q <= {1'b0, ats_q} + {{(STAMP_W-OFF_W){offset[OFF_W-1]}}, offset};
		if (cmd.prep || cmd.mul_pad)
			prod_q <= NUM_W'(mul_in) * NUM_W'(NS_PER_S);
		if (cmd.adj_ld) begin
			adj_q <= STAMP_W'(quo) + STAMP_W'(vts_q);
			bad_q <= (vts_q == '0) || (still_q > STILL_LIMIT_NS);
		end
		if (cmd.diff)
			diff_q <= rd_q[E_W-1 -: STAMP_W] - adj_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			last_q  <= '0;
			first_q <= '0;
			still_q <= '0;
			pnd_vld_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				head_q  <= '0;
				count_q <= '0;
				last_q  <= '0;
				first_q <= '0;
				still_q <= '0;
			end
			if (cmd.prep) begin
				last_q <= now_q;
				if (stale) begin
					head_q  <= '0;
					count_q <= '0;
				end
			end
			if (cmd.enq) begin
				if (full)
					pnd_vld_q <= 1'b1;
				else
					count_q <= count_q + 1'b1;
			end
			if (cmd.still_upd) begin
				if (first_q == '0)
					first_q <= vts_q;
				else if (first_q == vts_q)
					still_q <= still_sum[STAMP_W] ? '1 : still_sum[STAMP_W-1:0];
				else
					still_q <= '0;
			end
			if (cmd.pop) begin
				head_q    <= head_nx;
				count_q   <= count_q - 1'b1;
				pnd_vld_q <= 1'b1;
			end else if (cmd.push && cmd.push_last) begin
				pnd_vld_q <= 1'b0;
			end
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq && full) begin
			pnd_tag_q <= tag_q;
			pnd_fr_q  <= frames_q;
			pnd_act_q <= ACT_REJECT;
		end
		if (cmd.pop) begin
			pnd_tag_q <= rd_q[TAG_W-1:0];
			pnd_fr_q  <= rd_q[TAG_W +: FR_W];
			pnd_act_q <= sts.drop ? ACT_DROP : ACT_PLAY;
		end
		if (cmd.push) begin
			out_tag_q  <= pnd_tag_q;
			out_act_q  <= pnd_act_q;
			out_fr_q   <= pnd_fr_q;
			out_last_q <= cmd.push_last;
		end
	end

	always_comb begin
		sts            = '0;
		sts.op         = op;
		sts.div_done   = div_done;
		sts.count_zero = (count_q == '0);
		sts.hold       = !bad_all && !neg && win;
		sts.drop       = !bad_all && neg && win && (count_q > CW'(1));
		sts.pnd_vld    = pnd_vld_q;
		sts.out_free   = out_free;
	end

	assign out_valid  = out_valid_q;
	assign out_tag    = out_tag_q;
	assign action     = out_act_q;
	assign out_frames = out_fr_q;
	assign last       = out_last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH)) else $error("queue count above depth");
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(head_q) < DEPTH_L) else $error("queue head out of range");
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (out_free && pnd_vld_q)) else $error("push without room or request");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> count_q != '0) else $error("pop from empty queue");

endmodule

/* rtl/av_srg_ctrl.sv */
module av_srg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  av_srg_pkg::sts_t sts,
	output av_srg_pkg::cmd_t cmd
);
	import av_srg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PREP, ST_ENQ, ST_DIV1, ST_MUL2, ST_START2, ST_DIV2,
		ST_WALK, ST_DIFF, ST_DEC, ST_FIN
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.op)
						cmd.clear = 1'b1;
					else
						state_nx = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_nx = ST_ENQ;
			end
			ST_ENQ: begin
				cmd.enq       = 1'b1;
				cmd.div_start = 1'b1;
				state_nx      = ST_DIV1;
			end
			ST_DIV1: begin
				if (sts.div_done) begin
					cmd.still_upd = 1'b1;
					state_nx      = ST_MUL2;
				end
			end
			ST_MUL2: begin
				cmd.mul_pad = 1'b1;
				state_nx    = ST_START2;
			end
			ST_START2: begin
				cmd.div_start = 1'b1;
				state_nx      = ST_DIV2;
			end
			ST_DIV2: begin
				if (sts.div_done) begin
					cmd.adj_ld = 1'b1;
					state_nx   = ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.count_zero) begin
					state_nx = ST_FIN;
				end else begin
					cmd.rd   = 1'b1;
					state_nx = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_nx = ST_DEC;
			end
			ST_DEC: begin
				if (sts.hold) begin
					state_nx = ST_FIN;
				end else if (!sts.pnd_vld || sts.out_free) begin
					cmd.pop  = 1'b1;
					cmd.push = sts.pnd_vld;
					state_nx = sts.drop ? ST_WALK : ST_FIN;
				end
			end
			ST_FIN: begin
				if (!sts.pnd_vld) begin
					state_nx = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_last = 1'b1;
					state_nx      = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	assign in_ready = (state_q == ST_IDLE);

	a_walk_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !sts.pnd_vld) else $error("request left pending at idle");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done) else $error("divider done right after start");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> in_ready) else $error("load outside idle");

endmodule

/* rtl/av_sync_audio_release_gate_core.sv */
// Audio release gate: queues audio block descriptors with the sync offset applied and, per
// block, reports rejects, drops of dragging blocks and at most one block to play. One request
// is worked at a time; its time grows with the number of head entries examined, up to
// QUEUE_DEPTH of them, when results are taken at once. Two frame-to-nanosecond divisions in
// the shared divider and a queue walk that reads, compares and decides on one head entry
// at a time set this; a result that cannot leave stalls the walk until the output frees. Each result
// waits in an output register, so the next request may be taken while it is still unread.
// Registers sit at byte 0 (output rate in Hz) and 8 (sync offset in ns).
module av_sync_audio_release_gate_core #(
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_FRAMES  = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [av_srg_pkg::ADDR_W-1:0]  paddr,
	input  logic [av_srg_pkg::DATA_W-1:0]  pwdata,
	output logic [av_srg_pkg::DATA_W-1:0]  prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           op,
	input  logic [av_srg_pkg::TAG_W-1:0]   block_tag,
	input  logic [av_srg_pkg::FR_W-1:0]    frame_count,
	input  logic [av_srg_pkg::TS_W-1:0]    audio_ts,
	input  logic [av_srg_pkg::TS_W-1:0]    video_ts,
	input  logic [av_srg_pkg::TS_W-1:0]    now_ns,
	input  logic [av_srg_pkg::PAD_W-1:0]   pad_frames,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [av_srg_pkg::TAG_W-1:0]   out_tag,
	output logic [av_srg_pkg::ACT_W-1:0]   action,
	output logic [av_srg_pkg::FR_W-1:0]    out_frames,
	output logic                           last
);
	import av_srg_pkg::*;

	logic [RATE_W-1:0] rate_q;
	logic [OFF_W-1:0]  offset_q;
	logic              wr_en;
	logic              reg_sel;
	cmd_t              cmd;
	sts_t              sts;

	assign pready  = 1'b1;
	assign reg_sel = paddr[ADDR_W-1];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= RATE_W'(48000);
			offset_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_RATE:   rate_q   <= pwdata[RATE_W-1:0];
				REG_OFFSET: offset_q <= pwdata[OFF_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_RATE:   prdata = DATA_W'(rate_q);
			REG_OFFSET: prdata = {{(DATA_W-OFF_W){offset_q[OFF_W-1]}}, offset_q};
			default:    prdata = '0;
		endcase
	end

	av_srg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	av_srg_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_FRAMES  (MAX_FRAMES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.block_tag   (block_tag),
		.frame_count (frame_count),
		.audio_ts    (audio_ts),
		.video_ts    (video_ts),
		.now_ns      (now_ns),
		.pad_frames  (pad_frames),
		.rate        (rate_q),
		.offset      (offset_q),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_tag     (out_tag),
		.action      (action),
		.out_frames  (out_frames),
		.last        (last)
	);

endmodule
